// ----- src/two_node_thermal_forecast_macros.svh -----
// Assertion macros used by the thermal forecast top level.
`ifndef TWO_NODE_THERMAL_FORECAST_MACROS_SVH
`define TWO_NODE_THERMAL_FORECAST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TNF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tnf_pkg.sv -----
// Types, constants and codes for the two-node thermal forecast block.
package tnf_pkg;

  localparam int unsigned TempW     = 16;
  localparam int unsigned CoefW     = 24;
  localparam int unsigned DtW       = 12;
  localparam int unsigned HorW      = 17;
  localparam int unsigned FracW     = 24;
  localparam int unsigned HeatShift = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned DefaultMaxSteps  = 4096;
  localparam int unsigned StepSecondsReset = 60;

  // datapath widths
  localparam int unsigned DiffW = TempW + 1;
  localparam int unsigned ProdW = DiffW + CoefW + 1;
  localparam int unsigned AccW  = ProdW + 1;
  localparam int unsigned SumW  = AccW - FracW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_OA      = 3'd0,
    CFG_COEF_MA      = 3'd1,
    CFG_COEF_AM      = 3'd2,
    CFG_COEF_HEAT    = 3'd3,
    CFG_STEP_SECONDS = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_MUL_OA,
    PH_MUL_MA,
    PH_MUL_AM,
    PH_UPDATE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic   load;
    logic   run;
    phase_e phase;
  } mac_ctrl_t;

endpackage

// ----- src/tnf_if.sv -----
// Valid/ready channel interfaces for forecast requests and results.
interface tnf_in_if;
  import tnf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] air_temp_start;
  logic signed [TempW-1:0] mass_temp_start;
  logic signed [TempW-1:0] outdoor_temp;
  logic                    heater_en;
  logic        [HorW-1:0]  horizon_seconds;

  modport source (
    output valid, air_temp_start, mass_temp_start, outdoor_temp, heater_en,
           horizon_seconds,
    input  ready
  );
  modport sink (
    input  valid, air_temp_start, mass_temp_start, outdoor_temp, heater_en,
           horizon_seconds,
    output ready
  );
endinterface

interface tnf_out_if;
  import tnf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] predicted_air_temp;
  logic                    steps_capped;

  modport source (
    output valid, predicted_air_temp, steps_capped,
    input  ready
  );
  modport sink (
    input  valid, predicted_air_temp, steps_capped,
    output ready
  );
endinterface

// ----- src/two_node_thermal_forecast.sv -----
// Top level of the two-node (2R2C) thermal forecast engine.
// Usage:
//   in_i  : forecast request beat (start air/mass temps, outdoor temp,
//           heater flag, horizon in seconds); taken when valid & ready.
//   out_o : result beat (final air temp, cap flag); held until ready.
//   cfg   : cfg_we_i writes cfg_data_i into register cfg_idx_i; unknown
//           indexes are dropped. Write only while no request is in flight.
// Timing:
//   One request at a time. After acceptance a restoring divider forms
//   n = horizon / step (step 0 counts as 1, n capped at 4096), then the
//   Euler steps run on the one shared 17x25 multiplier. The next request
//   can be taken as soon as the result beat is valid.
// Reset:
//   rst_ni clears control state and reloads the coefficient registers
//   (all zero, step length 60 s). The output register parts the result
//   from the next request: a new beat is accepted while a result still
//   waits; a stalled receiver only holds the block when the next result
//   is ready to leave.
module two_node_thermal_forecast #(
  parameter int unsigned MAX_STEPS = tnf_pkg::DefaultMaxSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tnf_in_if.sink                        in_i,
  tnf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [tnf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tnf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tnf_pkg::*;

`include "two_node_thermal_forecast_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);
  localparam logic [HorW-1:0] MaxStepsQuo = HorW'(MAX_STEPS);
  localparam logic [CntW-1:0] MaxStepsCnt = CntW'(MAX_STEPS);

  // configuration registers
  logic [CoefW-1:0] coef_oa_q, coef_ma_q, coef_am_q, coef_heat_q;
  logic [DtW-1:0]   step_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_oa_q   <= '0;
      coef_ma_q   <= '0;
      coef_am_q   <= '0;
      coef_heat_q <= '0;
      step_sec_q  <= DtW'(StepSecondsReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_OA:      coef_oa_q   <= cfg_data_i[CoefW-1:0];
        CFG_COEF_MA:      coef_ma_q   <= cfg_data_i[CoefW-1:0];
        CFG_COEF_AM:      coef_am_q   <= cfg_data_i[CoefW-1:0];
        CFG_COEF_HEAT:    coef_heat_q <= cfg_data_i[CoefW-1:0];
        CFG_STEP_SECONDS: step_sec_q  <= cfg_data_i[DtW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] step_cnt_q, step_cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic            capped_q, capped_d;
  logic            out_valid_q, out_valid_d;
  logic signed [TempW-1:0] out_temp_q;
  logic            out_capped_q;

  logic            acc_in;
  logic            out_load;
  logic            div_busy, div_done;
  logic [HorW-1:0] div_quo;
  logic [DtW-1:0]  div_den;
  logic            quo_over;
  mac_ctrl_t       mac_ctrl;
  logic signed [TempW-1:0] mac_air;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc_in     = in_i.valid && in_i.ready;
  assign div_den    = (step_sec_q == '0) ? DtW'(1) : step_sec_q;
  assign quo_over   = div_quo > MaxStepsQuo;

  tnf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_in),
    .num_i   (in_i.horizon_seconds),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  tnf_mac u_mac (
    .clk_i       (clk_i),
    .ctrl_i      (mac_ctrl),
    .air_i       (in_i.air_temp_start),
    .mass_i      (in_i.mass_temp_start),
    .outdoor_i   (in_i.outdoor_temp),
    .heat_i      (in_i.heater_en),
    .coef_oa_i   (coef_oa_q),
    .coef_ma_i   (coef_ma_q),
    .coef_am_i   (coef_am_q),
    .coef_heat_i (coef_heat_q),
    .air_o       (mac_air)
  );

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    step_cnt_d     = step_cnt_q;
    n_d            = n_q;
    capped_d       = capped_q;
    out_valid_d    = out_valid_q;
    out_load       = 1'b0;
    mac_ctrl.load  = acc_in;
    mac_ctrl.run   = 1'b0;
    mac_ctrl.phase = phase_q;

    // result taken by the receiver
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          capped_d   = quo_over;
          n_d        = quo_over ? MaxStepsCnt : div_quo[CntW-1:0];
          step_cnt_d = '0;
          phase_d    = PH_MUL_OA;
          // horizon shorter than one step: no step runs
          state_d    = (quo_over || div_quo != '0) ? ST_STEP : ST_FINISH;
        end
      end
      ST_STEP: begin
        mac_ctrl.run = 1'b1;
        unique case (phase_q)
          PH_MUL_OA: phase_d = PH_MUL_MA;
          PH_MUL_MA: phase_d = PH_MUL_AM;
          PH_MUL_AM: phase_d = PH_UPDATE;
          PH_UPDATE: begin
            phase_d    = PH_MUL_OA;
            step_cnt_d = step_cnt_q + CntW'(1);
            if (step_cnt_q == n_q - CntW'(1)) begin
              state_d = ST_FINISH;
            end
          end
          default: phase_d = PH_MUL_OA;
        endcase
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MUL_OA;
      step_cnt_q  <= '0;
      n_q         <= '0;
      capped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_cnt_q  <= step_cnt_d;
      n_q         <= n_d;
      capped_q    <= capped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_temp_q   <= mac_air;
      out_capped_q <= capped_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.predicted_air_temp = out_temp_q;
  assign out_o.steps_capped       = out_capped_q;

  `TNF_ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, acc_in, state_q == ST_DIV,
                   "accepted request did not start the divider")
  `TNF_ASSERT_NOW(a_div_active, clk_i, rst_ni, state_q == ST_DIV, div_busy || div_done,
                  "waiting on an idle divider")
  `TNF_ASSERT_NOW(a_step_bound, clk_i, rst_ni, state_q == ST_STEP, step_cnt_q < n_q,
                  "step counter ran past the step count")
  `TNF_ASSERT_NOW(a_cap_count, clk_i, rst_ni, capped_q, n_q == MaxStepsCnt,
                  "capped request without the capped step count")
  `TNF_ASSERT_NOW(a_result_origin, clk_i, rst_ni, $rose(out_valid_q),
                  $past(state_q == ST_FINISH), "result beat raised outside the finish state")

endmodule

// ----- src/tnf_div.sv -----
// Restoring divider: horizon / step length, one quotient bit per cycle.
module tnf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tnf_pkg::HorW-1:0]  num_i,
  input  logic [tnf_pkg::DtW-1:0]   den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [tnf_pkg::HorW-1:0]  quo_o
);
  import tnf_pkg::*;

  localparam int unsigned CntW = $clog2(HorW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [HorW-1:0] quo_q, quo_d;
  logic [DtW-1:0]  rem_q, rem_d;
  logic [DtW-1:0]  den_q, den_d;
  logic [DtW:0]    rem_sh;
  logic [DtW:0]    trial;

  // shift next dividend bit into the partial remainder, try a subtract
  assign rem_sh = {rem_q, quo_q[HorW-1]};
  assign trial  = rem_sh - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = CntW'(HorW);
      busy_d = 1'b1;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[DtW]) begin
        rem_d = trial[DtW-1:0];
        quo_d = {quo_q[HorW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DtW-1:0];
        quo_d = {quo_q[HorW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/tnf_mac.sv -----
// Shared multiplier, accumulator and node registers for the Euler steps.
module tnf_mac (
  input  logic                            clk_i,
  input  tnf_pkg::mac_ctrl_t              ctrl_i,
  input  logic signed [tnf_pkg::TempW-1:0] air_i,
  input  logic signed [tnf_pkg::TempW-1:0] mass_i,
  input  logic signed [tnf_pkg::TempW-1:0] outdoor_i,
  input  logic                            heat_i,
  input  logic [tnf_pkg::CoefW-1:0]       coef_oa_i,
  input  logic [tnf_pkg::CoefW-1:0]       coef_ma_i,
  input  logic [tnf_pkg::CoefW-1:0]       coef_am_i,
  input  logic [tnf_pkg::CoefW-1:0]       coef_heat_i,
  output logic signed [tnf_pkg::TempW-1:0] air_o
);
  import tnf_pkg::*;

  // clamp a widened sum back to the temperature range
  function automatic logic signed [TempW-1:0] sat_temp(input logic signed [SumW-1:0] x);
    logic [SumW-TempW:0] top;
    top = x[SumW-1:TempW-1];
    if (top == '0 || top == '1) begin
      sat_temp = x[TempW-1:0];
    end else if (x[SumW-1]) begin
      sat_temp = {1'b1, {(TempW-1){1'b0}}};
    end else begin
      sat_temp = {1'b0, {(TempW-1){1'b1}}};
    end
  endfunction

  logic signed [TempW-1:0] ta_q, tm_q, te_q;
  logic                    heat_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  logic signed [DiffW-1:0] op_diff;
  logic signed [CoefW:0]   op_coef;
  logic signed [ProdW-1:0] mul;
  logic signed [AccW-1:0]  heat_term;
  logic signed [SumW-1:0]  air_sum, mass_sum;

  always_comb begin
    unique case (ctrl_i.phase)
      PH_MUL_OA: begin
        op_diff = DiffW'(te_q) - DiffW'(ta_q);
        op_coef = {1'b0, coef_oa_i};
      end
      PH_MUL_MA: begin
        op_diff = DiffW'(tm_q) - DiffW'(ta_q);
        op_coef = {1'b0, coef_ma_i};
      end
      PH_MUL_AM: begin
        op_diff = DiffW'(ta_q) - DiffW'(tm_q);
        op_coef = {1'b0, coef_am_i};
      end
      default: begin
        op_diff = '0;
        op_coef = '0;
      end
    endcase
  end

  assign mul       = op_diff * op_coef;
  assign heat_term = heat_q ? AccW'({coef_heat_i, {HeatShift{1'b0}}}) : '0;
  // arithmetic shift is floor division by 2^FracW
  assign air_sum   = SumW'(ta_q) + SumW'(acc_q >>> FracW);
  assign mass_sum  = SumW'(tm_q) + SumW'(prod_q >>> FracW);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ta_q   <= air_i;
      tm_q   <= mass_i;
      te_q   <= outdoor_i;
      heat_q <= heat_i;
    end else if (ctrl_i.run) begin
      unique case (ctrl_i.phase)
        PH_MUL_OA: begin
          prod_q <= mul;
        end
        PH_MUL_MA: begin
          acc_q  <= AccW'(prod_q);
          prod_q <= mul;
        end
        PH_MUL_AM: begin
          acc_q  <= acc_q + AccW'(prod_q) + heat_term;
          prod_q <= mul;
        end
        PH_UPDATE: begin
          ta_q <= sat_temp(air_sum);
          tm_q <= sat_temp(mass_sum);
        end
        default: begin
        end
      endcase
    end
  end

  assign air_o = ta_q;

endmodule
